FILE: hdl/prps_pkg.sv
// Shared constants, codes and types of the page replacement core.
package prps_pkg;

    // Build-time defaults.
    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int AGE_W    = 16;
    localparam int CNT_W    = 16;
    localparam int TIME_W   = 32;
    localparam int TOTAL_W  = 32;
    localparam int POL_W    = 2;
    localparam int NFR_W    = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 5;
    localparam int PAGE_W   = 16;
    localparam int FRAME_W  = 4;

    // Replacement policy codes.
    localparam logic [POL_W-1:0] POLICY_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POLICY_LRU  = 2'd1;
    localparam logic [POL_W-1:0] POLICY_LFU  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [POL_W-1:0] POLICY_RST     = POLICY_FIFO;
    localparam logic [NFR_W-1:0] NUM_FRAMES_RST = 5'd4;

    // Match flags from the frame scan.
    typedef struct packed {
        logic hit;
        logic empty_found;
    } scan_flags_t;

endpackage

FILE: hdl/prps_ram.sv
// Generic simple dual-port RAM with registered read data.
module prps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word and register one read each cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/prps_scan.sv
// Frame scan unit: hit search, first empty, oldest age and least used, one frame a cycle while en is high.
module prps_scan #(
    parameter int NUM_FRAMES = prps_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = prps_pkg::PAGE_BITS_DEF,
    localparam int FB = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [FB-1:0]               idx,
    input  logic                        fvalid,
    input  logic [PAGE_BITS-1:0]        tag,
    input  logic [prps_pkg::AGE_W-1:0]  age,
    input  logic [prps_pkg::CNT_W-1:0]  cnt,
    input  logic [prps_pkg::TIME_W-1:0] load,
    input  logic [PAGE_BITS-1:0]        page,
    output prps_pkg::scan_flags_t       flags,
    output logic [FB-1:0]               hit_idx,
    output logic [FB-1:0]               empty_idx,
    output logic [FB-1:0]               age_idx,
    output logic [FB-1:0]               lfu_idx
);
    import prps_pkg::*;

    logic              hit_reg, empty_reg;
    logic [FB-1:0]     hit_idx_reg, empty_idx_reg, age_idx_reg, lfu_idx_reg;
    logic [AGE_W-1:0]  age_best_reg;
    logic [CNT_W-1:0]  cnt_best_reg;
    logic [TIME_W-1:0] load_best_reg;
    logic              first, match, take_hit, take_empty, take_age, take_lfu;

    // Compare this frame against the best so far.
    always_comb
    begin
        first      = (idx == '0);
        match      = fvalid && (tag == page);
        take_hit   = match && (first || !hit_reg);
        take_empty = !fvalid && (first || !empty_reg);
        take_age   = first || (age > age_best_reg);
        take_lfu   = first || (cnt < cnt_best_reg) ||
                     ((cnt == cnt_best_reg) && (load < load_best_reg));
    end

    // Hold the flags; the first frame restarts the search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (en)
        begin
            hit_reg   <= first ? match   : (hit_reg | match);
            empty_reg <= first ? !fvalid : (empty_reg | !fvalid);
        end
    end

    // Track candidate indexes and best keys.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (take_hit)
            begin
                hit_idx_reg <= idx;
            end
            if (take_empty)
            begin
                empty_idx_reg <= idx;
            end
            if (take_age)
            begin
                age_idx_reg  <= idx;
                age_best_reg <= age;
            end
            if (take_lfu)
            begin
                lfu_idx_reg   <= idx;
                cnt_best_reg  <= cnt;
                load_best_reg <= load;
            end
        end
    end

    assign flags.hit         = hit_reg;
    assign flags.empty_found = empty_reg;
    assign hit_idx           = hit_idx_reg;
    assign empty_idx         = empty_idx_reg;
    assign age_idx           = age_idx_reg;
    assign lfu_idx           = lfu_idx_reg;
endmodule

FILE: hdl/page_replacement_policy_sim_core.sv
// Top level of the page replacement core: control sequencer and frame update.
//
// Usage: pulse start with page and first_of_run while busy is low; the request
// transfers at that edge and busy rises. Frame state (tag, age, use count, load
// time) sits in one RAM; valid bits sit in flip-flops. Each request first reads
// the frames in use one per cycle to find a hit, the lowest empty frame, the
// oldest frame and the least used frame, then picks the slot, then makes a
// second read-modify-write pass over the same frames to store the new tag and
// bump ages or counts. Both passes are bound by the single RAM read port.
// A new request is taken only after done, once busy has fallen.
// The result (hit, frame_used, evicted_valid, evicted_page, hit_total,
// fault_total) shows for exactly one cycle with done; the receiver cannot stall.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only while
// idle. Reset empties every frame, zeroes totals and times and sets policy fifo
// and 4 frames; first_of_run does the same for the run state, without a sweep.
module page_replacement_policy_sim_core #(
    parameter int NUM_FRAMES = prps_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = prps_pkg::PAGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [prps_pkg::PAGE_W-1:0]    page,
    input  logic                           first_of_run,
    output logic                           done,
    output logic                           hit,
    output logic [prps_pkg::FRAME_W-1:0]   frame_used,
    output logic                           evicted_valid,
    output logic [prps_pkg::PAGE_W-1:0]    evicted_page,
    output logic [prps_pkg::TOTAL_W-1:0]   hit_total,
    output logic [prps_pkg::TOTAL_W-1:0]   fault_total,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [prps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prps_pkg::CFG_DAT_W-1:0] cfg_data
);
    import prps_pkg::*;

    localparam int FB  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NFW = $clog2(NUM_FRAMES + 1);
    localparam int CW  = (NFW > NFR_W) ? NFW : NFR_W;
    localparam int DW  = PAGE_BITS + AGE_W + CNT_W + TIME_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [POL_W-1:0]      policy_reg;
    logic [NFR_W-1:0]      num_frames_reg;
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [FB-1:0]         ptr_reg;
    logic [TIME_W-1:0]     req_time_reg;
    logic [TOTAL_W-1:0]    hit_cnt_reg, fault_cnt_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [NFW-1:0]        addr_reg;
    logic                  rd_vld_reg, rd_last_reg;
    logic [FB-1:0]         rd_idx_reg;
    logic [FB-1:0]         slot_reg;
    logic                  hit_reg, ev_valid_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;

    logic                  accept, is_lru, is_lfu, issue, pass_end;
    logic [CW-1:0]         nf_wide;
    logic [NFW-1:0]        nf;
    logic [DW-1:0]         rdata, wdata;
    logic                  we;
    logic [PAGE_BITS-1:0]  d_tag;
    logic [AGE_W-1:0]      d_age, e_age, n_age;
    logic [CNT_W-1:0]      d_cnt, e_cnt, n_cnt;
    logic [TIME_W-1:0]     d_load, e_load, n_load;
    logic                  v, is_slot, nv;
    scan_flags_t           flags;
    logic [FB-1:0]         hit_idx, empty_idx, age_idx, lfu_idx;
    logic [FB-1:0]         fifo_p, slot_c;
    logic [NFW-1:0]        fifo_p1;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign is_lru    = (policy_reg == POLICY_LRU);
    assign is_lfu    = (policy_reg == POLICY_LFU);

    // Clamp the frame count into 1..NUM_FRAMES.
    always_comb
    begin
        if (num_frames_reg == '0)
        begin
            nf_wide = CW'(1);
        end
        else if (CW'(num_frames_reg) > CW'(NUM_FRAMES))
        begin
            nf_wide = CW'(NUM_FRAMES);
        end
        else
        begin
            nf_wide = CW'(num_frames_reg);
        end
        nf = NFW'(nf_wide);
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= POLICY_RST;
            num_frames_reg <= NUM_FRAMES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POLICY:     policy_reg     <= POL_W'(cfg_data);
                REG_NUM_FRAMES: num_frames_reg <= NFR_W'(cfg_data);
                default:        ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept)   state_next = S_SCAN;
            S_SCAN: if (pass_end) state_next = S_DEC;
            S_DEC:                state_next = S_UPD;
            S_UPD:  if (pass_end) state_next = S_OUT;
            S_OUT:                state_next = S_IDLE;
            default:              state_next = S_IDLE;
        endcase
    end

    // Frame read pipeline shared by both passes.
    assign issue    = ((state_reg == S_SCAN) || (state_reg == S_UPD)) && (addr_reg < nf);
    assign pass_end = rd_vld_reg && rd_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (issue)
            begin
                addr_reg <= addr_reg + NFW'(1);
            end
            else if ((state_reg == S_IDLE) || (state_reg == S_DEC))
            begin
                addr_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= addr_reg[FB-1:0];
        rd_last_reg <= (addr_reg == nf - NFW'(1));
    end

    prps_ram #(
        .WIDTH(DW),
        .DEPTH(NUM_FRAMES)
    ) u_frames (
        .clk  (clk),
        .we   (we),
        .waddr(rd_idx_reg),
        .wdata(wdata),
        .raddr(addr_reg[FB-1:0]),
        .rdata(rdata)
    );

    // Unpack the returned frame; an empty frame reads as zero counters.
    always_comb
    begin
        {d_tag, d_age, d_cnt, d_load} = rdata;
        v      = valid_reg[rd_idx_reg];
        e_age  = v ? d_age  : '0;
        e_cnt  = v ? d_cnt  : '0;
        e_load = v ? d_load : '0;
    end

    prps_scan #(
        .NUM_FRAMES(NUM_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rd_vld_reg && (state_reg == S_SCAN)),
        .idx      (rd_idx_reg),
        .fvalid   (v),
        .tag      (d_tag),
        .age      (e_age),
        .cnt      (e_cnt),
        .load     (e_load),
        .page     (page_reg),
        .flags    (flags),
        .hit_idx  (hit_idx),
        .empty_idx(empty_idx),
        .age_idx  (age_idx),
        .lfu_idx  (lfu_idx)
    );

    // Pick the slot: hit frame, empty frame, policy victim or fifo pointer.
    always_comb
    begin
        fifo_p  = (NFW'(ptr_reg) >= nf) ? '0 : ptr_reg;
        fifo_p1 = NFW'(fifo_p) + NFW'(1);
        if (flags.hit)
        begin
            slot_c = hit_idx;
        end
        else if (is_lru || is_lfu)
        begin
            if (flags.empty_found)
            begin
                slot_c = empty_idx;
            end
            else
            begin
                slot_c = is_lru ? age_idx : lfu_idx;
            end
        end
        else
        begin
            slot_c = fifo_p;
        end
    end

    // Build the write-back word for the frame in the update pass.
    always_comb
    begin
        is_slot = (rd_idx_reg == slot_reg);
        nv      = v || (is_slot && !hit_reg);
        n_age   = e_age;
        n_cnt   = e_cnt;
        n_load  = e_load;
        if (is_slot && is_lru)
        begin
            n_age = '0;
        end
        if (is_slot && is_lfu)
        begin
            if (hit_reg)
            begin
                n_cnt = (e_cnt == '1) ? e_cnt : e_cnt + CNT_W'(1);
            end
            else
            begin
                n_cnt  = CNT_W'(1);
                n_load = req_time_reg;
            end
        end
        if (is_lru && nv && (n_age != '1))
        begin
            n_age = n_age + AGE_W'(1);
        end
        wdata = {((is_slot && !hit_reg) ? page_reg : d_tag), n_age, n_cnt, n_load};
        we    = rd_vld_reg && (state_reg == S_UPD);
    end

    // Run state: clear on first_of_run, count requests/hits/faults, step fifo ptr, set valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ptr_reg       <= '0;
            req_time_reg  <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (first_of_run)
            begin
                valid_reg     <= '0;
                ptr_reg       <= '0;
                req_time_reg  <= TIME_W'(1);
                hit_cnt_reg   <= '0;
                fault_cnt_reg <= '0;
            end
            else if (req_time_reg != '1)
            begin
                req_time_reg <= req_time_reg + TIME_W'(1);
            end
        end
        else if (state_reg == S_DEC)
        begin
            if (flags.hit)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_reg <= hit_cnt_reg + TOTAL_W'(1);
                end
            end
            else
            begin
                if (fault_cnt_reg != '1)
                begin
                    fault_cnt_reg <= fault_cnt_reg + TOTAL_W'(1);
                end
                if (!is_lru && !is_lfu)
                begin
                    ptr_reg <= (fifo_p1 >= nf) ? '0 : FB'(fifo_p1);
                end
            end
        end
        else if ((state_reg == S_OUT) && !hit_reg)
        begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // Hold request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= PAGE_BITS'(page);
        end
        if (state_reg == S_DEC)
        begin
            slot_reg <= slot_c;
            hit_reg  <= flags.hit;
        end
        if (we && is_slot)
        begin
            ev_valid_reg <= !hit_reg && v;
            ev_page_reg  <= (!hit_reg && v) ? d_tag : '0;
        end
    end

    assign done          = (state_reg == S_OUT);
    assign hit           = hit_reg;
    assign frame_used    = FRAME_W'(slot_reg);
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = PAGE_W'(ev_page_reg);
    assign hit_total     = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;
endmodule

FILE: hdl/prps_checker.sv
// Port-level checker for the page replacement core, with its bind.
module prps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           hit,
    input logic                           evicted_valid,
    input logic [prps_pkg::PAGE_W-1:0]    evicted_page
);
    import prps_pkg::*;

    // A result only appears while a request is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");

    // A result strobe lasts one cycle and frees the block.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy)) else $error("done not a single pulse");

    // A transfer always starts work.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request not started");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted_valid) else $error("eviction on hit");

    // Without an eviction the evicted page reads as zero.
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted_valid) |-> (evicted_page == '0))
        else $error("evicted page without eviction");
endmodule

bind page_replacement_policy_sim_core prps_checker u_prps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page)
);

FILE: tb/page_replacement_policy_sim_core_checker.sv
// Checker of the page replacement core: predicts each lookup result and compares it.
module page_replacement_policy_sim_core_checker
    import prps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [PAGE_W-1:0]    page,
    input  logic                 first_of_run,
    input  logic                 done,
    input  logic                 hit,
    input  logic [FRAME_W-1:0]   frame_used,
    input  logic                 evicted_valid,
    input  logic [PAGE_W-1:0]    evicted_page,
    input  logic [TOTAL_W-1:0]   hit_total,
    input  logic [TOTAL_W-1:0]   fault_total,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   lookups_done,
    output int                   hits_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = NUM_FRAMES_DEF;

    typedef struct {
        bit               hit;
        bit [FRAME_W-1:0] frame;
        bit               ev_valid;
        bit [PAGE_W-1:0]  ev_page;
        bit [TOTAL_W-1:0] hits;
        bit [TOTAL_W-1:0] faults;
    } lookup_t;

    lookup_t lookup_q[$];

    // Shadow of the frame store and the run counters
    bit [PAGE_W-1:0]  tag_m [NF];
    bit               vld_m [NF];
    bit [AGE_W-1:0]   age_m [NF];
    bit [CNT_W-1:0]   cnt_m [NF];
    bit [TIME_W-1:0]  ltime_m [NF];
    int               fifo_ptr;
    bit [TIME_W-1:0]  req_time;
    bit [TOTAL_W-1:0] hit_cnt;
    bit [TOTAL_W-1:0] fault_cnt;
    bit [POL_W-1:0]   pol_m;
    bit [NFR_W-1:0]   nfr_m;

    task automatic clear_run();
        for (int i = 0; i < NF; i++)
        begin
            tag_m[i] = '0;
            vld_m[i] = 1'b0;
            age_m[i] = '0;
            cnt_m[i] = '0;
            ltime_m[i] = '0;
        end
        fifo_ptr = 0;
        req_time = '0;
        hit_cnt = '0;
        fault_cnt = '0;
    endtask

    // Work out the result of one request and update the shadow state
    task automatic predict_lookup(input bit [PAGE_W-1:0] pg, input bit fresh);
        lookup_t r;
        int nf;
        int slot;
        int empty_slot;
        bit found;
        r = '{default: 0};
        slot = 0;
        found = 1'b0;
        empty_slot = -1;
        if (fresh)
            clear_run();
        nf = (nfr_m == 0) ? 1 : ((nfr_m > NF) ? NF : int'(nfr_m));
        if (req_time != '1)
            req_time++;
        for (int i = 0; i < nf; i++)
        begin
            if (!found && vld_m[i] && tag_m[i] == pg)
            begin
                found = 1'b1;
                slot = i;
            end
        end
        if (found)
        begin
            if (hit_cnt != '1)
                hit_cnt++;
            if (pol_m == POLICY_LRU)
                age_m[slot] = '0;
            else if (pol_m == POLICY_LFU && cnt_m[slot] != '1)
                cnt_m[slot]++;
        end
        else
        begin
            if (fault_cnt != '1)
                fault_cnt++;
            if (pol_m == POLICY_LRU || pol_m == POLICY_LFU)
            begin
                for (int i = nf - 1; i >= 0; i--)
                    if (!vld_m[i])
                        empty_slot = i;
                if (empty_slot >= 0)
                    slot = empty_slot;
                else if (pol_m == POLICY_LRU)
                begin
                    slot = 0;
                    for (int i = 1; i < nf; i++)
                        if (age_m[i] > age_m[slot])
                            slot = i;
                end
                else
                begin
                    slot = 0;
                    for (int i = 1; i < nf; i++)
                        if (cnt_m[i] < cnt_m[slot] ||
                            (cnt_m[i] == cnt_m[slot] && ltime_m[i] < ltime_m[slot]))
                            slot = i;
                end
            end
            else
            begin
                // fifo, and the unused policy code behaves the same
                if (fifo_ptr >= nf)
                    fifo_ptr = 0;
                slot = fifo_ptr;
                fifo_ptr = (fifo_ptr + 1 >= nf) ? 0 : fifo_ptr + 1;
            end
            if (vld_m[slot])
            begin
                r.ev_valid = 1'b1;
                r.ev_page = tag_m[slot];
            end
            tag_m[slot] = pg;
            vld_m[slot] = 1'b1;
            if (pol_m == POLICY_LRU)
                age_m[slot] = '0;
            else if (pol_m == POLICY_LFU)
            begin
                cnt_m[slot] = 1;
                ltime_m[slot] = req_time;
            end
        end
        if (pol_m == POLICY_LRU)
            for (int i = 0; i < nf; i++)
                if (vld_m[i] && age_m[i] != '1)
                    age_m[i]++;
        r.hit = found;
        r.frame = slot[FRAME_W-1:0];
        r.hits = hit_cnt;
        r.faults = fault_cnt;
        lookup_q.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t e;
        if (!rst_n)
        begin
            clear_run();
            pol_m = POLICY_RST;
            nfr_m = NUM_FRAMES_RST;
            lookup_q.delete();
        end
        else
        begin
            // Compare a finished lookup with the oldest prediction
            if (done)
            begin
                lookups_done++;
                if (hit)
                    hits_done++;
                if (lookup_q.size() == 0)
                    note_mismatch("unexpected result", 0, 1);
                else
                begin
                    e = lookup_q.pop_front();
                    if (hit !== e.hit)
                        note_mismatch("hit", e.hit, hit);
                    if (frame_used !== e.frame)
                        note_mismatch("frame_used", e.frame, frame_used);
                    if (evicted_valid !== e.ev_valid)
                        note_mismatch("evicted_valid", e.ev_valid, evicted_valid);
                    if (evicted_page !== e.ev_page)
                        note_mismatch("evicted_page", e.ev_page, evicted_page);
                    if (hit_total !== e.hits)
                        note_mismatch("hit_total", e.hits, hit_total);
                    if (fault_total !== e.faults)
                        note_mismatch("fault_total", e.faults, fault_total);
                end
            end
            // Apply a register transfer
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POLICY)
                    pol_m = cfg_data[POL_W-1:0];
                else if (cfg_index == REG_NUM_FRAMES)
                    nfr_m = cfg_data;
            end
            // Predict an accepted request
            if (start && !busy)
                predict_lookup(page, first_of_run);
        end
        pending = lookup_q.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
        lookups_done = 0;
        hits_done = 0;
    end

endmodule

FILE: tb/tb_page_replacement_policy_sim_core.sv
// Testbench top of the page replacement core: stimulus, register writes and verdict.
module tb_page_replacement_policy_sim_core;
    import prps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PAGE_W-1:0]    page = '0;
    logic                 first_of_run = 1'b0;
    logic                 done;
    logic                 hit;
    logic [FRAME_W-1:0]   frame_used;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   fault_total;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int errors;
    int pending;
    int lookups_done;
    int hits_done;
    int cycles = 0;
    int reg_writes = 0;
    bit allow_gaps = 1'b1;

    always #5 clk = ~clk;

    page_replacement_policy_sim_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .page(page),
        .first_of_run(first_of_run), .done(done), .hit(hit), .frame_used(frame_used),
        .evicted_valid(evicted_valid), .evicted_page(evicted_page),
        .hit_total(hit_total), .fault_total(fault_total), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    page_replacement_policy_sim_core_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .page(page),
        .first_of_run(first_of_run), .done(done), .hit(hit), .frame_used(frame_used),
        .evicted_valid(evicted_valid), .evicted_page(evicted_page),
        .hit_total(hit_total), .fault_total(fault_total), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .lookups_done(lookups_done),
        .hits_done(hits_done)
    );

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[page_replacement_policy_sim_core] ERROR");
            $finish;
        end
    end

    // Drive one request from a falling edge, return at the falling edge after transfer or a random gap
    task automatic send_request(input logic [PAGE_W-1:0] pg, input logic fresh);
        int gap;
        start <= 1'b1;
        page <= pg;
        first_of_run <= fresh;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (allow_gaps && $urandom_range(0, 9) < 3)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drain outstanding lookups, then write one register while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= dat;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Policy write with random upper data bits, which the register drops, then the frame count
    task automatic set_mode(input logic [POL_W-1:0] pol, input logic [NFR_W-1:0] nfr);
        write_reg(REG_POLICY, {3'($urandom), pol});
        write_reg(REG_NUM_FRAMES, nfr);
    endtask

    initial
    begin
        logic [PAGE_W-1:0] base;
        logic [NFR_W-1:0] nfr;
        int span;
        int n;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fifo with four frames out of reset, page extremes and a refill
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h0002, 1'b0);
        send_request(16'h0003, 1'b0);
        send_request(16'hFFFF, 1'b1);
        send_request(16'hFFFF, 1'b0);

        // Least recently used on three frames: a hit refreshes, the oldest goes
        set_mode(POLICY_LRU, 5'd3);
        send_request(16'h0010, 1'b1);
        send_request(16'h0011, 1'b0);
        send_request(16'h0012, 1'b0);
        send_request(16'h0010, 1'b0);
        send_request(16'h0013, 1'b0);
        send_request(16'h0012, 1'b0);

        // Least frequently used on two frames: count first, then load time
        set_mode(POLICY_LFU, 5'd2);
        send_request(16'h0005, 1'b1);
        send_request(16'h0005, 1'b0);
        send_request(16'h0006, 1'b0);
        send_request(16'h0007, 1'b0);

        // Unused policy code, zero frames, then more frames than built
        set_mode(2'd3, 5'd0);
        send_request(16'h0001, 1'b0);
        send_request(16'h0002, 1'b0);
        set_mode(POLICY_FIFO, 5'd31);
        send_request(16'h5A5A, 1'b0);
        send_request(16'hA5A5, 1'b0);

        // Ignored register indexes
        write_reg(4'd2, 5'd1);
        write_reg(4'd15, 5'd31);
        write_reg(4'd12, 5'd0);

        // Random phases; settings mix extremes, state carries across policies
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: nfr = 5'd1;
                1: nfr = 5'd16;
                2: nfr = (ph == 2) ? 5'd0 : 5'd31;
                default: nfr = 5'($urandom_range(1, 16));
            endcase
            set_mode(2'($urandom), nfr);
            if (ph >= 10)
                allow_gaps = 1'b0;
            base = 16'($urandom);
            span = ((nfr == 0) ? 1 : ((nfr > 16) ? 16 : int'(nfr))) + 3;
            n = 80 + $urandom_range(0, 10);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(16'($urandom), $urandom_range(0, 29) == 0);
                else
                    send_request(base + 16'($urandom_range(0, span)),
                                 $urandom_range(0, 29) == 0);
            end
        end

        // Drain and settle
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d lookups (%0d hits) across fifo, lru and lfu", lookups_done,
                 hits_done);
        $display("with %0d register writes, frame counts 0 to 31; %0d mismatches", reg_writes,
                 errors);
        if (errors == 0 && pending == 0)
            $display("[page_replacement_policy_sim_core] OK");
        else
            $display("[page_replacement_policy_sim_core] ERROR");
        $finish;
    end

endmodule
